>>> design/hts_pkg.sv
// hts_pkg: shared types and codes for handle_table_store.
// No dependencies.
`default_nettype none
package hts_pkg;
	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_UNLINK = 3'd1,
		OP_OPEN   = 3'd2,
		OP_CLOSE  = 3'd3,
		OP_WRITE  = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_BUSY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DESC,
		S_OBJ,
		S_COMMIT,
		S_OUT
	} state_t;

	// Query broadcast along a cell chain.
	typedef struct packed {
		logic [63:0] key;
		logic        cmp_num;  // compare stored number
		logic        cmp_tgt;  // compare stored target (descriptor cells)
	} query_t;

	// Hit flags passed from cell to cell, lowest slot first.
	typedef struct packed {
		logic found;   // a lower slot already matched
		logic free;    // a lower slot is already free
	} chain_t;
endpackage
`default_nettype wire

>>> design/hts_obj_cell.sv
// hts_obj_cell: one object slot (valid, number, value).
// Depends on hts_pkg.
`default_nettype none
module hts_obj_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hts_pkg::query_t   query,
	input  wire hts_pkg::chain_t   chain_in,
	output hts_pkg::chain_t        chain_out,
	input  wire logic [63:0]       data_in,
	output logic      [63:0]       data_out,
	output logic                   hit,       // this slot is the first match
	output logic                   first_free,
	input  wire logic              do_alloc,  // write new number, clear value
	input  wire logic              do_free,
	input  wire logic              do_write,
	input  wire logic [63:0]       new_number,
	input  wire logic [63:0]       wr_value
);
	logic        valid_q;
	logic [63:0] number_q;
	logic [63:0] value_q;
	logic        match;

	assign match      = valid_q && query.cmp_num && number_q == query.key;
	assign hit        = match && !chain_in.found;
	assign first_free = !valid_q && !chain_in.free;
	assign chain_out.found = chain_in.found || match;
	assign chain_out.free  = chain_in.free || !valid_q;
	// Value ripples down; the matching slot inserts its own.
	assign data_out = hit ? value_q : data_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			number_q <= '0;
		end else if (do_alloc) begin
			valid_q  <= 1'b1;
			number_q <= new_number;
		end else if (do_free) begin
			valid_q  <= 1'b0;
			number_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc)
			value_q <= '0;
		else if (do_write)
			value_q <= wr_value;
	end
endmodule
`default_nettype wire

>>> design/hts_desc_cell.sv
// hts_desc_cell: one descriptor slot (valid, number, target).
// Depends on hts_pkg.
`default_nettype none
module hts_desc_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hts_pkg::query_t   query,
	input  wire hts_pkg::chain_t   chain_in,
	output hts_pkg::chain_t        chain_out,
	input  wire logic [63:0]       tgt_in,
	output logic      [63:0]       tgt_out,
	output logic                   hit,
	output logic                   first_free,
	input  wire logic              do_alloc,
	input  wire logic              do_free,
	input  wire logic [63:0]       new_number,
	input  wire logic [63:0]       new_target
);
	logic        valid_q;
	logic [63:0] number_q;
	logic [63:0] target_q;
	logic        match;

	assign match = valid_q && ((query.cmp_num && number_q == query.key) ||
		(query.cmp_tgt && target_q == query.key));
	assign hit        = match && !chain_in.found;
	assign first_free = !valid_q && !chain_in.free;
	assign chain_out.found = chain_in.found || match;
	assign chain_out.free  = chain_in.free || !valid_q;
	assign tgt_out = hit ? target_q : tgt_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			number_q <= '0;
		end else if (do_alloc) begin
			valid_q  <= 1'b1;
			number_q <= new_number;
		end else if (do_free) begin
			valid_q  <= 1'b0;
			number_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc)
			target_q <= new_target;
	end
endmodule
`default_nettype wire

>>> design/handle_table_store.sv
// handle_table_store: top level, sequencer plus object and descriptor cell rows.
// Depends on hts_pkg, hts_obj_cell, hts_desc_cell.
//
// Usage:
//  Input stream s_axis_*: tdata = {zero, write_value, handle, operation},
//  see port notes; one transfer is one operation (create, unlink, open,
//  close, write, read).
//  Output stream m_axis_*: one transfer per operation with status and data.
//  The state lives in two rows of slot cells. A query key is broadcast to
//  every cell; hit and free flags ripple from the lowest slot upward, so
//  the lowest matching or lowest free slot wins.
//  Each accepted operation goes through a descriptor lookup step, then a
//  commit step (create/unlink/open/close) or an object lookup by the
//  descriptor's target (write/read), then the output step. The single
//  shared sequencer walks each operation through these steps one at a time,
//  so a new operation is not accepted until the last one is through.
//  The result sits in an output register; the next operation is accepted
//  once it is transferred, so while the receiver stalls s_axis_tready
//  simply stays low. Reset (arst_n low) clears all valid bits, numbers
//  and both counters; it stands for the init call.
`default_nettype none
module handle_table_store #(
	parameter int OBJECT_SLOTS = 16,
	parameter int DESC_SLOTS   = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// [2:0] operation, [66:3] handle, [130:67] write_value, [135:131] zero
	input  wire logic [135:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// [1:0] status, [65:2] data_out, [71:66] zero
	output logic      [71:0]   m_axis_tdata
);
	hts_pkg::state_t state_q, state_d;

	logic [2:0]  op_q;
	logic [63:0] handle_q;
	logic [63:0] wval_q;
	logic [63:0] obj_ctr_q, desc_ctr_q;
	logic [63:0] tgt_q;          // target of the matched descriptor
	logic        dhit_q;         // descriptor lookup result
	logic        dref_q;         // a descriptor targets the object
	logic [1:0]  status_q;
	logic [63:0] data_q;

	hts_pkg::query_t oquery, dquery;

	// object chain
	hts_pkg::chain_t ochain [OBJECT_SLOTS+1];
	logic [63:0]     odata  [OBJECT_SLOTS+1];
	logic [OBJECT_SLOTS-1:0] ohit, ofree;
	logic o_alloc, o_free, o_write;

	// descriptor chain
	hts_pkg::chain_t dchain [DESC_SLOTS+1];
	logic [63:0]     dtgt   [DESC_SLOTS+1];
	logic [DESC_SLOTS-1:0] dhit, dfree;
	logic d_alloc, d_free;

	logic ofound, dfound, ohas_free, dhas_free;

	assign ochain[0] = '0;
	assign odata[0]  = '0;
	assign dchain[0] = '0;
	assign dtgt[0]   = '0;
	assign ofound    = ochain[OBJECT_SLOTS].found;
	assign ohas_free = ochain[OBJECT_SLOTS].free;
	assign dfound    = dchain[DESC_SLOTS].found;
	assign dhas_free = dchain[DESC_SLOTS].free;

	for (genvar i = 0; i < OBJECT_SLOTS; i++) begin : g_obj
		hts_obj_cell u_cell (
			.clk, .arst_n,
			.query(oquery),
			.chain_in(ochain[i]), .chain_out(ochain[i+1]),
			.data_in(odata[i]), .data_out(odata[i+1]),
			.hit(ohit[i]), .first_free(ofree[i]),
			.do_alloc(o_alloc && ofree[i]),
			.do_free(o_free && ohit[i]),
			.do_write(o_write && ohit[i]),
			.new_number(obj_ctr_q + 64'd1),
			.wr_value(wval_q)
		);
	end

	for (genvar j = 0; j < DESC_SLOTS; j++) begin : g_desc
		hts_desc_cell u_cell (
			.clk, .arst_n,
			.query(dquery),
			.chain_in(dchain[j]), .chain_out(dchain[j+1]),
			.tgt_in(dtgt[j]), .tgt_out(dtgt[j+1]),
			.hit(dhit[j]), .first_free(dfree[j]),
			.do_alloc(d_alloc && dfree[j]),
			.do_free(d_free && dhit[j]),
			.new_number(desc_ctr_q + 64'd1),
			.new_target(handle_q)
		);
	end

	assign s_axis_tready = (state_q == hts_pkg::S_IDLE);
	assign m_axis_tvalid = (state_q == hts_pkg::S_OUT);
	assign m_axis_tdata  = {6'd0, data_q, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hts_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Object query: by handle, or by the descriptor's target in the S_OBJ step.
	always_comb begin
		oquery.key     = (state_q == hts_pkg::S_OBJ) ? tgt_q : handle_q;
		oquery.cmp_num = 1'b1;
		oquery.cmp_tgt = 1'b0;
		// unlink: ask for a descriptor targeting handle; others: by number
		dquery.key     = handle_q;
		dquery.cmp_num = (op_q != hts_pkg::OP_UNLINK);
		dquery.cmp_tgt = (op_q == hts_pkg::OP_UNLINK);
	end

	always_comb begin
		state_d = state_q;
		o_alloc = 1'b0;
		o_free  = 1'b0;
		o_write = 1'b0;
		d_alloc = 1'b0;
		d_free  = 1'b0;
		case (state_q)
			hts_pkg::S_IDLE:   if (s_axis_tvalid) state_d = hts_pkg::S_DESC;
			hts_pkg::S_DESC:   state_d = (op_q == hts_pkg::OP_WRITE ||
				op_q == hts_pkg::OP_READ) ? hts_pkg::S_OBJ : hts_pkg::S_COMMIT;
			hts_pkg::S_OBJ:    begin
				o_write = dhit_q && (op_q == hts_pkg::OP_WRITE);
				state_d = hts_pkg::S_OUT;
			end
			hts_pkg::S_COMMIT: begin
				case (op_q)
					hts_pkg::OP_CREATE: o_alloc = ohas_free;
					hts_pkg::OP_UNLINK: o_free  = ofound && !dref_q;
					hts_pkg::OP_OPEN:   d_alloc = ofound && dhas_free;
					hts_pkg::OP_CLOSE:  d_free  = dfound;
					default: ;
				endcase
				state_d = hts_pkg::S_OUT;
			end
			hts_pkg::S_OUT:    if (m_axis_tready) state_d = hts_pkg::S_IDLE;
			default:           state_d = hts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_ctr_q  <= '0;
			desc_ctr_q <= '0;
		end else begin
			if (o_alloc)
				obj_ctr_q <= obj_ctr_q + 64'd1;
			if (d_alloc)
				desc_ctr_q <= desc_ctr_q + 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hts_pkg::S_IDLE: if (s_axis_tvalid) begin
				op_q     <= s_axis_tdata[2:0];
				handle_q <= s_axis_tdata[66:3];
				wval_q   <= s_axis_tdata[130:67];
			end
			hts_pkg::S_DESC: begin
				dhit_q <= dfound;
				dref_q <= dfound;
				tgt_q  <= dtgt[DESC_SLOTS];
			end
			hts_pkg::S_OBJ: begin
				if (dhit_q && ofound) begin
					status_q <= hts_pkg::ST_OK;
					data_q   <= (op_q == hts_pkg::OP_READ) ? odata[OBJECT_SLOTS] : 64'd0;
				end else begin
					status_q <= hts_pkg::ST_FAIL;
					data_q   <= '0;
				end
			end
			hts_pkg::S_COMMIT: begin
				status_q <= hts_pkg::ST_FAIL;
				data_q   <= '0;
				case (op_q)
					hts_pkg::OP_CREATE: if (ohas_free) begin
						status_q <= hts_pkg::ST_OK;
						data_q   <= obj_ctr_q + 64'd1;
					end
					hts_pkg::OP_UNLINK: if (ofound)
						status_q <= dref_q ? hts_pkg::ST_BUSY : hts_pkg::ST_OK;
					hts_pkg::OP_OPEN: if (ofound && dhas_free) begin
						status_q <= hts_pkg::ST_OK;
						data_q   <= desc_ctr_q + 64'd1;
					end
					hts_pkg::OP_CLOSE: if (dfound)
						status_q <= hts_pkg::ST_OK;
					default: ;
				endcase
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> verif/handle_table_store_tb.sv
// handle_table_store_tb: self-checking testbench for handle_table_store.
// Depends on hts_pkg and the handle_table_store RTL. A local model of both slot
// tables predicts each result; directed and random operation streams are checked.
`default_nettype none
module handle_table_store_tb;
	localparam int OBJ_SLOTS   = 16;
	localparam int DSC_SLOTS   = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_OPS  = 1250;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		hts_pkg::status_t status;
		logic [63:0]      data;
	} result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;

	// model of the block state
	logic        obj_used [OBJ_SLOTS];
	logic [63:0] obj_num  [OBJ_SLOTS];
	logic [63:0] obj_val  [OBJ_SLOTS];
	logic        dsc_used [DSC_SLOTS];
	logic [63:0] dsc_num  [DSC_SLOTS];
	logic [63:0] dsc_tgt  [DSC_SLOTS];
	logic [63:0] obj_count, dsc_count;

	result_t pending_results[$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      no_gaps = 1'b0;

	handle_table_store #(.OBJECT_SLOTS(OBJ_SLOTS), .DESC_SLOTS(DSC_SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic int find_obj(logic [63:0] num);
		for (int i = 0; i < OBJ_SLOTS; i++)
			if (obj_used[i] && obj_num[i] == num) return i;
		return -1;
	endfunction

	function automatic int find_dsc(logic [63:0] num);
		for (int i = 0; i < DSC_SLOTS; i++)
			if (dsc_used[i] && dsc_num[i] == num) return i;
		return -1;
	endfunction

	// apply one operation to the model, return the expected result
	function automatic result_t table_step(logic [2:0] op, logic [63:0] h, logic [63:0] v);
		result_t r;
		int s, o;
		bit refd;
		r.status = hts_pkg::ST_FAIL;
		r.data = '0;
		case (op)
			hts_pkg::OP_CREATE: begin
				for (int i = 0; i < OBJ_SLOTS; i++)
					if (!obj_used[i]) begin
						obj_count = obj_count + 64'd1;
						obj_num[i] = obj_count;
						obj_val[i] = '0;
						obj_used[i] = 1'b1;
						r = '{hts_pkg::ST_OK, obj_count};
						break;
					end
			end
			hts_pkg::OP_UNLINK: begin
				s = find_obj(h);
				if (s >= 0) begin
					refd = 1'b0;
					for (int i = 0; i < DSC_SLOTS; i++)
						if (dsc_used[i] && dsc_tgt[i] == h) refd = 1'b1;
					if (refd) r.status = hts_pkg::ST_BUSY;
					else begin
						obj_used[s] = 1'b0;
						obj_num[s] = '0;
						r.status = hts_pkg::ST_OK;
					end
				end
			end
			hts_pkg::OP_OPEN: begin
				if (find_obj(h) >= 0)
					for (int i = 0; i < DSC_SLOTS; i++)
						if (!dsc_used[i]) begin
							dsc_count = dsc_count + 64'd1;
							dsc_num[i] = dsc_count;
							dsc_tgt[i] = h;
							dsc_used[i] = 1'b1;
							r = '{hts_pkg::ST_OK, dsc_count};
							break;
						end
			end
			hts_pkg::OP_CLOSE: begin
				s = find_dsc(h);
				if (s >= 0) begin
					dsc_used[s] = 1'b0;
					dsc_num[s] = '0;
					r.status = hts_pkg::ST_OK;
				end
			end
			hts_pkg::OP_WRITE, hts_pkg::OP_READ: begin
				s = find_dsc(h);
				if (s >= 0) begin
					o = find_obj(dsc_tgt[s]);
					if (o >= 0) begin
						if (op == hts_pkg::OP_WRITE) obj_val[o] = v;
						else r.data = obj_val[o];
						r.status = hts_pkg::ST_OK;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one operation, wait for the transfer, record the prediction
	task automatic send_op(logic [2:0] op, logic [63:0] h, logic [63:0] v);
		while (!no_gaps && $urandom_range(99) < 21) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {5'd0, v, h, op};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(table_step(op, h, v));
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// a live object number most of the time, noise otherwise
	function automatic logic [63:0] pick_obj();
		int s = $urandom_range(OBJ_SLOTS - 1);
		if ($urandom_range(9) == 0)
			return ($urandom_range(1) != 0) ? rand64() : obj_count + 64'd1;
		for (int i = 0; i < OBJ_SLOTS; i++)
			if (obj_used[(s + i) % OBJ_SLOTS]) return obj_num[(s + i) % OBJ_SLOTS];
		return rand64();
	endfunction

	function automatic logic [63:0] pick_dsc();
		int s = $urandom_range(DSC_SLOTS - 1);
		if ($urandom_range(9) == 0)
			return ($urandom_range(1) != 0) ? rand64() : dsc_count + 64'd1;
		for (int i = 0; i < DSC_SLOTS; i++)
			if (dsc_used[(s + i) % DSC_SLOTS]) return dsc_num[(s + i) % DSC_SLOTS];
		return rand64();
	endfunction

	// fill the object table past full, hit busy, field extremes, then free and reuse a slot
	task automatic test_directed;
		send_op(hts_pkg::OP_READ, 64'd0, '0);
		send_op(hts_pkg::OP_UNLINK, 64'd1, '0);
		send_op(hts_pkg::OP_OPEN, '1, '0);
		repeat (OBJ_SLOTS + 1) send_op(hts_pkg::OP_CREATE, '1, '1);
		send_op(hts_pkg::OP_OPEN, 64'd1, '0);
		send_op(hts_pkg::OP_WRITE, 64'd1, '1);
		send_op(hts_pkg::OP_READ, 64'd1, '0);
		send_op(hts_pkg::OP_WRITE, 64'd1, 64'h5555_AAAA_0F0F_F0F0);
		send_op(hts_pkg::OP_READ, 64'd1, '1);
		send_op(hts_pkg::OP_UNLINK, 64'd1, '0);   // still referenced
		send_op(hts_pkg::OP_CLOSE, 64'd1, '0);
		send_op(hts_pkg::OP_CLOSE, 64'd1, '0);    // already closed
		send_op(hts_pkg::OP_UNLINK, 64'd1, '0);
		send_op(hts_pkg::OP_OPEN, 64'd1, '0);     // object gone
		send_op(hts_pkg::OP_CREATE, '0, '0);      // reuses the freed slot
		drain();
	endtask

	task automatic test_table_full;
		repeat (DSC_SLOTS + 1) send_op(hts_pkg::OP_OPEN, 64'd2, rand64());
		send_op(hts_pkg::OP_READ, 64'd3, '0);
		for (int i = 2; i <= DSC_SLOTS + 2; i++) send_op(hts_pkg::OP_CLOSE, 64'(i), '0);
		drain();
	endtask

	task automatic test_spare_codes;
		send_op(OP_SPARE6, 64'd2, '1);
		send_op(OP_SPARE7, '1, '1);
		drain();
	endtask

	task automatic test_random;
		int w;
		logic [2:0] op;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			no_gaps = (n >= 400 && n < 600);
			w = $urandom_range(99);
			if (w < 3) op = ($urandom_range(1) != 0) ? OP_SPARE6 : OP_SPARE7;
			else if (w < 18) op = hts_pkg::OP_CREATE;
			else if (w < 30) op = hts_pkg::OP_UNLINK;
			else if (w < 48) op = hts_pkg::OP_OPEN;
			else if (w < 62) op = hts_pkg::OP_CLOSE;
			else if (w < 81) op = hts_pkg::OP_WRITE;
			else op = hts_pkg::OP_READ;
			case (op)
				hts_pkg::OP_UNLINK, hts_pkg::OP_OPEN: send_op(op, pick_obj(), rand64());
				hts_pkg::OP_CREATE:   send_op(op, rand64(), rand64());
				OP_SPARE6, OP_SPARE7: send_op(op, rand64(), rand64());
				default:              send_op(op, pick_dsc(), rand64());
			endcase
		end
		no_gaps = 1'b0;
		drain();
	endtask

	// receiver back-pressure, with the same gap-free stretch as the sender
	always @(negedge clk)
		m_axis_tready <= no_gaps || ($urandom_range(99) >= 21);

	// result checker
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				errors++;
			end else begin
				result_t exp_r;
				exp_r = pending_results.pop_front();
				if (m_axis_tdata[1:0] !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, m_axis_tdata[1:0]);
					errors++;
				end
				if (m_axis_tdata[65:2] !== exp_r.data) begin
					$display("%0t: data_out expected %h actual %h", $time,
						exp_r.data, m_axis_tdata[65:2]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("handle_table_store_tb: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < OBJ_SLOTS; i++) begin
			obj_used[i] = 1'b0; obj_num[i] = '0; obj_val[i] = '0;
		end
		for (int i = 0; i < DSC_SLOTS; i++) begin
			dsc_used[i] = 1'b0; dsc_num[i] = '0; dsc_tgt[i] = '0;
		end
		obj_count = '0;
		dsc_count = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_spare_codes();
		test_random();
		if (errors == 0)
			$display("handle_table_store_tb: PASS");
		else
			$display("handle_table_store_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
